// File: sv/hkim_pkg.sv
// ----------------------------------------------------------------------------
// hkim_pkg
// shared types, mod 26 reduction and the mod 26 inverse table for the
// hill key inverse pipeline
// ----------------------------------------------------------------------------
package hkim_pkg;

	typedef logic [4:0] res_t;

	typedef struct packed {
		logic ok;
		res_t val;
	} inv_t;

	localparam logic [10:0] Mod11   = 11'd26;
	localparam logic [4:0]  Mod5    = 5'd26;
	localparam logic [22:0] Recip26 = 23'd2521;
	localparam logic [10:0] Bias11  = 11'd650;

	// reduce a value below 2048 to 0..25 by reciprocal multiply
	function automatic res_t mod26(input logic [10:0] x);
		logic [22:0] prod;
		logic [6:0]  q;
		logic [10:0] r;
		prod = 23'(x) * Recip26;
		q    = prod[22:16];
		r    = x - 11'(q) * Mod11;
		return r[4:0];
	endfunction

	// reduce a 5-bit entry to 0..25
	function automatic res_t red5(input logic [4:0] x);
		return (x >= Mod5) ? x - Mod5 : x;
	endfunction

	// multiplicative inverse mod 26
	function automatic inv_t inv26(input res_t d);
		inv_t r;
		r.ok = 1'b1;
		unique case (d)
			5'd1:    r.val = 5'd1;
			5'd3:    r.val = 5'd9;
			5'd5:    r.val = 5'd21;
			5'd7:    r.val = 5'd15;
			5'd9:    r.val = 5'd3;
			5'd11:   r.val = 5'd19;
			5'd15:   r.val = 5'd7;
			5'd17:   r.val = 5'd23;
			5'd19:   r.val = 5'd11;
			5'd21:   r.val = 5'd5;
			5'd23:   r.val = 5'd17;
			5'd25:   r.val = 5'd25;
			default: begin
				r.ok  = 1'b0;
				r.val = 5'd0;
			end
		endcase
		return r;
	endfunction

endpackage

// File: sv/hkim_cof_lane.sv
// ----------------------------------------------------------------------------
// hkim_cof_lane
// one cofactor lane: x*y - z*w reduced mod 26, registered
// ----------------------------------------------------------------------------
module hkim_cof_lane (
	input  logic          clk,
	input  logic          en,
	input  hkim_pkg::res_t x,
	input  hkim_pkg::res_t y,
	input  hkim_pkg::res_t z,
	input  hkim_pkg::res_t w,
	output hkim_pkg::res_t cof_s2
);
	import hkim_pkg::*;

	logic [10:0] diff;

	// bias keeps the difference non-negative
	assign diff = 11'(x) * 11'(y) + Bias11 - 11'(z) * 11'(w);

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s2 <= mod26(diff);
		end
	end

endmodule

// File: sv/hkim_det.sv
// ----------------------------------------------------------------------------
// hkim_det
// merge stage: determinant from row 0 and the first adjugate column
// ----------------------------------------------------------------------------
module hkim_det (
	input  logic           clk,
	input  logic           en,
	input  hkim_pkg::res_t a0,
	input  hkim_pkg::res_t a1,
	input  hkim_pkg::res_t a2,
	input  hkim_pkg::res_t c0,
	input  hkim_pkg::res_t c1,
	input  hkim_pkg::res_t c2,
	output hkim_pkg::res_t det_s3
);
	import hkim_pkg::*;

	logic [10:0] sum;

	assign sum = 11'(a0) * 11'(c0) + 11'(a1) * 11'(c1) + 11'(a2) * 11'(c2);

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= mod26(sum);
		end
	end

endmodule

// File: sv/hkim_scale_lane.sv
// ----------------------------------------------------------------------------
// hkim_scale_lane
// one output lane: adjugate entry times inverse determinant mod 26
// ----------------------------------------------------------------------------
module hkim_scale_lane (
	input  logic           clk,
	input  logic           en,
	input  logic           ok,
	input  hkim_pkg::res_t adj,
	input  hkim_pkg::res_t dinv,
	output hkim_pkg::res_t v_s4
);
	import hkim_pkg::*;

	logic [10:0] prod;

	assign prod = 11'(adj) * 11'(dinv);

	always_ff @(posedge clk) begin
		if (en) begin
			v_s4 <= ok ? mod26(prod) : 5'd0;
		end
	end

endmodule

// File: sv/hill_key_inverse_mod26_top.sv
// ----------------------------------------------------------------------------
// hill_key_inverse_mod26_top
// an accepted item is registered in each stage below in turn before its result is valid
// throughput: one item per cycle, stalls only when the output is not taken
// stages: entry reduce, nine cofactor lanes, determinant, nine scale lanes
// reset: arst_n clears all stage valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
module hill_key_inverse_mod26_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     size,
	input  hkim_pkg::res_t k00,
	input  hkim_pkg::res_t k01,
	input  hkim_pkg::res_t k02,
	input  hkim_pkg::res_t k10,
	input  hkim_pkg::res_t k11,
	input  hkim_pkg::res_t k12,
	input  hkim_pkg::res_t k20,
	input  hkim_pkg::res_t k21,
	input  hkim_pkg::res_t k22,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           invertible,
	output hkim_pkg::res_t v00,
	output hkim_pkg::res_t v01,
	output hkim_pkg::res_t v02,
	output hkim_pkg::res_t v10,
	output hkim_pkg::res_t v11,
	output hkim_pkg::res_t v12,
	output hkim_pkg::res_t v20,
	output hkim_pkg::res_t v21,
	output hkim_pkg::res_t v22
);
	import hkim_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	res_t a_s1 [3][3];
	logic ok_s1, sz3_s1;
	res_t k_in [3][3];

	res_t opx [3][3];
	res_t opy [3][3];
	res_t opz [3][3];
	res_t opw [3][3];

	res_t adj_s2 [3][3];
	res_t row_s2 [3];
	logic ok_s2;

	res_t det_s3;
	res_t adj_s3 [3][3];
	logic ok_s3;

	inv_t dinv;
	logic inv_s4;
	res_t v_s4_m [3][3];

	// per-stage ready lets bubbles collapse
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign k_in[0][0] = k00;
	assign k_in[0][1] = k01;
	assign k_in[0][2] = k02;
	assign k_in[1][0] = k10;
	assign k_in[1][1] = k11;
	assign k_in[1][2] = k12;
	assign k_in[2][0] = k20;
	assign k_in[2][1] = k21;
	assign k_in[2][2] = k22;

	// stage 1: reduce entries
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					a_s1[r][c] <= red5(k_in[r][c]);
				end
			end
			ok_s1  <= size[1];
			sz3_s1 <= size[0];
		end
	end

	// lane operands: cyclic cofactors for 3x3, direct picks for 2x2
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				opx[i][j] = a_s1[(j + 1) % 3][(i + 1) % 3];
				opy[i][j] = a_s1[(j + 2) % 3][(i + 2) % 3];
				opz[i][j] = a_s1[(j + 1) % 3][(i + 2) % 3];
				opw[i][j] = a_s1[(j + 2) % 3][(i + 1) % 3];
				if (!sz3_s1) begin
					opx[i][j] = 5'd0;
					opy[i][j] = 5'd0;
					opz[i][j] = 5'd0;
					opw[i][j] = 5'd0;
				end
			end
		end
		if (!sz3_s1) begin
			opx[0][0] = a_s1[1][1];
			opy[0][0] = 5'd1;
			opz[0][1] = a_s1[0][1];
			opw[0][1] = 5'd1;
			opz[1][0] = a_s1[1][0];
			opw[1][0] = 5'd1;
			opx[1][1] = a_s1[0][0];
			opy[1][1] = 5'd1;
		end
	end

	// stage 2: nine cofactor lanes
	for (genvar i = 0; i < 3; i++) begin : g_cof_row
		for (genvar j = 0; j < 3; j++) begin : g_cof_col
			hkim_cof_lane u_cof (
				.clk    (clk),
				.en     (rdy2 && v_s1),
				.x      (opx[i][j]),
				.y      (opy[i][j]),
				.z      (opz[i][j]),
				.w      (opw[i][j]),
				.cof_s2 (adj_s2[i][j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			row_s2[0] <= a_s1[0][0];
			row_s2[1] <= a_s1[0][1];
			row_s2[2] <= sz3_s1 ? a_s1[0][2] : 5'd0;
			ok_s2     <= ok_s1;
		end
	end

	// stage 3: determinant
	hkim_det u_det (
		.clk    (clk),
		.en     (rdy3 && v_s2),
		.a0     (row_s2[0]),
		.a1     (row_s2[1]),
		.a2     (row_s2[2]),
		.c0     (adj_s2[0][0]),
		.c1     (adj_s2[1][0]),
		.c2     (adj_s2[2][0]),
		.det_s3 (det_s3)
	);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			adj_s3 <= adj_s2;
			ok_s3  <= ok_s2;
		end
	end

	// stage 4: inverse lookup and scale lanes
	assign dinv = inv26(det_s3);

	for (genvar i = 0; i < 3; i++) begin : g_scl_row
		for (genvar j = 0; j < 3; j++) begin : g_scl_col
			hkim_scale_lane u_scl (
				.clk  (clk),
				.en   (rdy4 && v_s3),
				.ok   (ok_s3 && dinv.ok),
				.adj  (adj_s3[i][j]),
				.dinv (dinv.val),
				.v_s4 (v_s4_m[i][j])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			inv_s4 <= ok_s3 && dinv.ok;
		end
	end

	assign out_valid  = v_s4;
	assign invertible = inv_s4;
	assign v00 = v_s4_m[0][0];
	assign v01 = v_s4_m[0][1];
	assign v02 = v_s4_m[0][2];
	assign v10 = v_s4_m[1][0];
	assign v11 = v_s4_m[1][1];
	assign v12 = v_s4_m[1][2];
	assign v20 = v_s4_m[2][0];
	assign v21 = v_s4_m[2][1];
	assign v22 = v_s4_m[2][2];

endmodule

// File: test/hill_key_inverse_mod26_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hill_key_inverse_mod26_top_test
// drives 2x2 and 3x3 hill key matrices, and keys of invalid size, into the inverse
// pipeline, with bursty input and a stalling output side, and checks every result
// field against an in-bench model of the mod 26 determinant, adjugate and inverse
// ----------------------------------------------------------------------------
module hill_key_inverse_mod26_top_test;

	import hkim_pkg::*;

	localparam int         KeyMod = 26;
	localparam logic [1:0] Dim0   = 2'd0;
	localparam logic [1:0] Dim1   = 2'd1;
	localparam logic [1:0] Dim2   = 2'd2;
	localparam logic [1:0] Dim3   = 2'd3;
	localparam int         MaxShown = 30;

	typedef struct packed {
		logic [1:0]           dim;
		res_t [2:0][2:0]      m;
	} key_item_t;

	typedef struct packed {
		logic                 ok;
		res_t [2:0][2:0]      m;
	} inverse_item_t;

	typedef enum {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PATTERN} take_mode_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [1:0] size       = Dim2;
	res_t       k00 = '0, k01 = '0, k02 = '0;
	res_t       k10 = '0, k11 = '0, k12 = '0;
	res_t       k20 = '0, k21 = '0, k22 = '0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic       invertible;
	res_t       v00, v01, v02, v10, v11, v12, v20, v21, v22;

	inverse_item_t expected_inverses[$];
	take_mode_t    take_mode     = TAKE_ALWAYS;
	int            hold_request  = 0;
	int            n_keys_sent   = 0;
	int            n_invertible  = 0;
	int            n_singular    = 0;
	int            n_in_stalls   = 0;
	int            n_errors      = 0;

	hill_key_inverse_mod26_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.size(size),
		.k00(k00), .k01(k01), .k02(k02),
		.k10(k10), .k11(k11), .k12(k12),
		.k20(k20), .k21(k21), .k22(k22),
		.out_valid(out_valid), .out_ready(out_ready),
		.invertible(invertible),
		.v00(v00), .v01(v01), .v02(v02),
		.v10(v10), .v11(v11), .v12(v12),
		.v20(v20), .v21(v21), .v22(v22)
	);

	always #2 clk = ~clk;

	function automatic int wrap26(input int x);
		int r;
		r = x % KeyMod;
		return (r < 0) ? r + KeyMod : r;
	endfunction

	function automatic inverse_item_t predict_inverse(input key_item_t key);
		inverse_item_t res;
		int a[3][3];
		int adj[3][3];
		int det;
		int dinv;
		res = '0;
		if (key.dim != Dim2 && key.dim != Dim3)
			return res;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				a[r][c]   = wrap26(int'(key.m[r][c]));
				adj[r][c] = 0;
			end
		if (key.dim == Dim2) begin
			det       = wrap26(a[0][0] * a[1][1] - a[0][1] * a[1][0]);
			adj[0][0] = a[1][1];
			adj[0][1] = wrap26(-a[0][1]);
			adj[1][0] = wrap26(-a[1][0]);
			adj[1][1] = a[0][0];
		end else begin
			// cyclic row and column picks carry the cofactor sign
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					adj[c][r] = wrap26(a[(r + 1) % 3][(c + 1) % 3] * a[(r + 2) % 3][(c + 2) % 3]
						- a[(r + 1) % 3][(c + 2) % 3] * a[(r + 2) % 3][(c + 1) % 3]);
			det = 0;
			for (int c = 0; c < 3; c++)
				det += a[0][c] * adj[c][0];
			det = wrap26(det);
		end
		dinv = -1;
		for (int t = 1; t < KeyMod; t++)
			if (dinv < 0 && (det * t) % KeyMod == 1)
				dinv = t;
		if (dinv < 0)
			return res;
		res.ok = 1'b1;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				res.m[r][c] = res_t'(wrap26(adj[r][c] * dinv));
		return res;
	endfunction

	function automatic key_item_t key_of(input logic [1:0] dim, input int e[9]);
		key_item_t key;
		key.dim = dim;
		for (int i = 0; i < 9; i++)
			key.m[i / 3][i % 3] = res_t'(e[i]);
		return key;
	endfunction

	function automatic key_item_t random_key();
		key_item_t key;
		int        wide;
		if ($urandom_range(0, 19) == 0)
			key.dim = $urandom_range(0, 1) ? Dim1 : Dim0;
		else
			key.dim = $urandom_range(0, 1) ? Dim3 : Dim2;
		// mostly proper residues, sometimes raw 5-bit values above 25
		wide = ($urandom_range(0, 3) == 0);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				key.m[r][c] = res_t'(wide ? $urandom_range(0, 31) : $urandom_range(0, 25));
		return key;
	endfunction

	task automatic send_key(input key_item_t key);
		@(negedge clk);
		in_valid <= 1'b1;
		size     <= key.dim;
		k00 <= key.m[0][0]; k01 <= key.m[0][1]; k02 <= key.m[0][2];
		k10 <= key.m[1][0]; k11 <= key.m[1][1]; k12 <= key.m[1][2];
		k20 <= key.m[2][0]; k21 <= key.m[2][1]; k22 <= key.m[2][2];
		do
			@(posedge clk);
		while (!in_ready);
		expected_inverses.push_back(predict_inverse(key));
		n_keys_sent++;
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_returned();
		idle_for(1);
		while (expected_inverses.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random_keys(input int count, input int max_gap);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 16);
			if (burst > left)
				burst = left;
			repeat (burst) send_key(random_key());
			left -= burst;
			if (max_gap > 0 && $urandom_range(0, 2) != 0)
				idle_for($urandom_range(1, max_gap));
		end
	endtask

	task automatic test_directed();
		take_mode = TAKE_ALWAYS;
		send_key(key_of(Dim2, '{1, 0, 0, 0, 1, 0, 0, 0, 0}));
		send_key(key_of(Dim3, '{1, 0, 0, 0, 1, 0, 0, 0, 1}));
		send_key(key_of(Dim3, '{6, 24, 1, 13, 16, 10, 20, 17, 15}));
		send_key(key_of(Dim2, '{3, 3, 31, 2, 5, 31, 31, 31, 31}));
		send_key(key_of(Dim2, '{0, 1, 0, 1, 0, 0, 0, 0, 0}));
		send_key(key_of(Dim2, '{13, 0, 0, 0, 1, 0, 0, 0, 0}));
		send_key(key_of(Dim2, '{2, 0, 0, 0, 1, 0, 0, 0, 0}));
		send_key(key_of(Dim3, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
		send_key(key_of(Dim3, '{25, 25, 25, 25, 25, 25, 25, 25, 25}));
		send_key(key_of(Dim3, '{25, 0, 0, 0, 25, 0, 0, 0, 25}));
		send_key(key_of(Dim3, '{27, 26, 26, 26, 27, 26, 26, 26, 27}));
		send_key(key_of(Dim3, '{31, 30, 2, 29, 28, 5, 1, 26, 31}));
		send_key(key_of(Dim2, '{31, 30, 0, 29, 28, 0, 0, 0, 0}));
		send_key(key_of(Dim0, '{1, 0, 0, 0, 1, 0, 0, 0, 1}));
		send_key(key_of(Dim1, '{1, 0, 0, 0, 1, 0, 0, 0, 1}));
		send_key(key_of(Dim1, '{31, 31, 31, 31, 31, 31, 31, 31, 31}));
		send_key(key_of(Dim3, '{2, 4, 6, 8, 10, 12, 14, 16, 18}));
		send_key(key_of(Dim2, '{5, 17, 4, 15, 0, 0, 0, 0, 0}));
		wait_all_returned();
	endtask

	task automatic test_random_bursts();
		take_mode = TAKE_ALWAYS;
		send_random_keys(150, 0);
		take_mode = TAKE_RANDOM;
		send_random_keys(250, 6);
		// sender holds back until the pipeline is empty
		wait_all_returned();
		take_mode = TAKE_PATTERN;
		send_random_keys(250, 3);
		take_mode = TAKE_RANDOM;
		send_random_keys(150, 10);
		wait_all_returned();
	endtask

	task automatic test_backpressure_fill();
		take_mode = TAKE_ALWAYS;
		@(posedge clk);
		hold_request = 60;
		repeat (40) send_key(random_key());
		wait_all_returned();
	endtask

	// output side stall pattern, with a long hold when asked for
	always @(negedge clk) begin
		static int               hold_left = 0;
		static logic [12:0]      take_bits = 13'b1011001110100;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		take_bits = {take_bits[11:0], take_bits[12]};
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (take_mode)
				TAKE_ALWAYS: out_ready <= 1'b1;
				TAKE_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
				default:     out_ready <= take_bits[0];
			endcase
		end
	end

	always @(posedge clk) begin
		inverse_item_t want;
		inverse_item_t got;
		if (arst_n) begin
			if (in_valid && !in_ready)
				n_in_stalls++;
			if (out_valid && out_ready) begin
				got.ok = invertible;
				got.m  = {v22, v21, v20, v12, v11, v10, v02, v01, v00};
				if (expected_inverses.size() == 0) begin
					n_errors++;
					if (n_errors <= MaxShown)
						$display("%0t: result expected none actual ok %0b", $time, got.ok);
				end else begin
					want = expected_inverses.pop_front();
					if (want.ok)
						n_invertible++;
					else
						n_singular++;
					if (got.ok !== want.ok) begin
						n_errors++;
						if (n_errors <= MaxShown)
							$display("%0t: invertible expected %0b actual %0b",
								$time, want.ok, got.ok);
					end
					for (int r = 0; r < 3; r++)
						for (int c = 0; c < 3; c++)
							if (got.m[r][c] !== want.m[r][c]) begin
								n_errors++;
								if (n_errors <= MaxShown)
									$display("%0t: v%0d%0d expected %0d actual %0d",
										$time, r, c, want.m[r][c], got.m[r][c]);
							end
				end
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure_fill();
		test_random_bursts();
		test_backpressure_fill();
		repeat (20) @(posedge clk);
		$display("covered %0d keys of sizes 0..3: %0d invertible, %0d singular or bad size",
			n_keys_sent, n_invertible, n_singular);
		$display("input side stalled for %0d cycles under output back pressure", n_in_stalls);
		if (n_errors == 0 && expected_inverses.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
